>>> hw/rtl/alpha_matte_boundary_extract_unit_macros.svh
// ----------------------------------------------------------------------------
// Alpha matte boundary extract assertion macros
// Concurrent check wrappers on clock and reset that vanish in synthesis.
// ----------------------------------------------------------------------------
`ifndef ALPHA_MATTE_BOUNDARY_EXTRACT_UNIT_MACROS_SVH
`define ALPHA_MATTE_BOUNDARY_EXTRACT_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define AMBE_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");
`define AMBE_ASSERT_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("forbidden condition seen");
`else
`define AMBE_ASSERT(label, prop)
`define AMBE_ASSERT_NEVER(label, cond)
`endif

`endif

>>> hw/rtl/ambe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha matte boundary extract package
// Sizes, register indexes and shared types of the outline extractor.
// ----------------------------------------------------------------------------
package ambe_pkg;

   localparam int MAX_WIDTH       = 2048;
   localparam int MAX_HEIGHT      = 2048;
   localparam int COL_WIDTH       = $clog2(MAX_WIDTH);
   localparam int ROW_WIDTH       = $clog2(MAX_HEIGHT);
   localparam int SIZE_WIDTH      = 12;
   localparam int ALPHA_WIDTH     = 8;
   localparam int COORD_WIDTH     = 11;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int REQ_TDATA_WIDTH = ((ALPHA_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_WIDTH = ((2 * COORD_WIDTH + 7) / 8) * 8;
   localparam int CMP_COL_WIDTH   = (SIZE_WIDTH > COL_WIDTH + 1) ? SIZE_WIDTH : COL_WIDTH + 1;
   localparam int CMP_ROW_WIDTH   = (SIZE_WIDTH > ROW_WIDTH + 1) ? SIZE_WIDTH : ROW_WIDTH + 1;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam int LINE_WIDTH      = 2;

   localparam logic [SIZE_WIDTH-1:0] WIDTH_RESET  = SIZE_WIDTH'(640);
   localparam logic [SIZE_WIDTH-1:0] HEIGHT_RESET = SIZE_WIDTH'(480);

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FRAME_WIDTH  = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FRAME_HEIGHT = CSR_INDEX_WIDTH'(1);

   localparam logic [8:0] WINDOW_FULL = 9'h1FF;

   typedef struct packed {
      logic                   is_outline;
      logic [COORD_WIDTH-1:0] pixel_col;
      logic [COORD_WIDTH-1:0] pixel_row;
      logic                   frame_done;
   } result_type;

   typedef struct packed {
      logic                 fg;
      logic [COL_WIDTH-1:0] col;
      logic [ROW_WIDTH-1:0] row;
      logic                 col_nz;
      logic                 row_nz;
      logic                 col_one;
      logic                 row_one;
      logic                 last_col;
      logic                 last_row;
   } stage_type;

endpackage

>>> hw/rtl/ambe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual port RAM
// One write port and one read port with registered, read-first output.
// ----------------------------------------------------------------------------
module ambe_ram #(
   parameter int DATA_WIDTH = 2,
   parameter int DEPTH      = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]    wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/alpha_matte_boundary_extract_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha matte boundary extract unit
// Streams a matte in raster order and flags 3x3 outline pixels one row late.
// ----------------------------------------------------------------------------
// A pixel is held in stage 1 and its results in the result queue before they
// are offered. Throughput: one pixel per clock while the queue has room;
// pixels with two or three results (last column, last row) drain through the
// one-result output port behind a four-entry queue. The line memory is read
// and written once per pixel. Reset is synchronous: it clears position,
// window and queue, loads 640 x 480, and leaves the line memory unwritten.
// ----------------------------------------------------------------------------
`include "alpha_matte_boundary_extract_unit_macros.svh"

module alpha_matte_boundary_extract_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ambe_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,  // alpha
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ambe_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,  // pixel_col, pixel_row, zeros
   output logic                                 rsp_tuser,  // is_outline
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ambe_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ambe_pkg::SIZE_WIDTH-1:0]      csr_data
);

   localparam int CW = ambe_pkg::COL_WIDTH;
   localparam int RW = ambe_pkg::ROW_WIDTH;
   localparam int QW = ambe_pkg::QUEUE_CNT_WIDTH;
   localparam int QD = ambe_pkg::QUEUE_DEPTH;

   logic [ambe_pkg::SIZE_WIDTH-1:0] frame_width_ff, frame_height_ff;
   logic [CW-1:0]                   col_ff, col_in, col_last;
   logic [RW-1:0]                   row_ff, row_in, row_last;
   logic [ambe_pkg::CMP_COL_WIDTH-1:0] fw_ext;
   logic [ambe_pkg::CMP_ROW_WIDTH-1:0] fh_ext;

   logic                       s1_valid_ff, s1_valid_in;
   ambe_pkg::stage_type        s1_ff, s1_in;
   logic                       fwd_ff, fwd_in;
   logic [ambe_pkg::LINE_WIDTH-1:0] fwd_data_ff, fwd_data_in;
   logic [8:0]                 window_ff, window_in;

   ambe_pkg::result_type       queue_ff [QD];
   ambe_pkg::result_type       queue_in [QD];
   logic [QW-1:0]              count_ff, count_in;

   logic                       req_accept, csr_write, pop, retire;
   logic [ambe_pkg::LINE_WIDTH-1:0] line_rd, line_old, line_wr;
   logic                       older_bit, prior_bit;
   logic [8:0]                 window_new;
   logic                       en0, en1, en2;
   logic [1:0]                 n_results;
   logic [QW-1:0]              base;
   logic [QW-1:0]              slot_idx;
   ambe_pkg::result_type       res0, res1, res2;
   ambe_pkg::result_type       pack [3];

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready &&
                       (csr_index == ambe_pkg::REG_FRAME_WIDTH ||
                        csr_index == ambe_pkg::REG_FRAME_HEIGHT);
   assign req_tready = !s1_valid_ff || retire;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;

   assign fw_ext = ambe_pkg::CMP_COL_WIDTH'(frame_width_ff);
   assign fh_ext = ambe_pkg::CMP_ROW_WIDTH'(frame_height_ff);

   always_comb begin
      if (fw_ext == '0) begin
         col_last = '0;
      end else if (fw_ext > ambe_pkg::CMP_COL_WIDTH'(ambe_pkg::MAX_WIDTH)) begin
         col_last = CW'(ambe_pkg::MAX_WIDTH - 1);
      end else begin
         col_last = CW'(fw_ext - 1'b1);
      end
      if (fh_ext == '0) begin
         row_last = '0;
      end else if (fh_ext > ambe_pkg::CMP_ROW_WIDTH'(ambe_pkg::MAX_HEIGHT)) begin
         row_last = RW'(ambe_pkg::MAX_HEIGHT - 1);
      end else begin
         row_last = RW'(fh_ext - 1'b1);
      end
   end

   // Stage 0: position bookkeeping and line memory read.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_write) begin
         col_in = '0;
         row_in = '0;
      end else if (req_accept) begin
         if (col_ff == col_last) begin
            col_in = '0;
            row_in = (row_ff == row_last) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      s1_in          = s1_ff;
      s1_in.fg       = (req_tdata[ambe_pkg::ALPHA_WIDTH-1:0] != '0);
      s1_in.col      = col_ff;
      s1_in.row      = row_ff;
      s1_in.col_nz   = (col_ff != '0);
      s1_in.row_nz   = (row_ff != '0);
      s1_in.col_one  = (col_ff == CW'(1));
      s1_in.row_one  = (row_ff == RW'(1));
      s1_in.last_col = (col_ff == col_last);
      s1_in.last_row = (row_ff == row_last);
      s1_valid_in    = req_accept || (s1_valid_ff && !retire);
      fwd_in         = req_accept && retire && (s1_ff.col == col_ff);
      fwd_data_in    = line_wr;
   end

   ambe_ram #(
      .DATA_WIDTH (ambe_pkg::LINE_WIDTH),
      .DEPTH      (ambe_pkg::MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (retire),
      .wr_addr (s1_ff.col),
      .wr_data (line_wr),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (line_rd)
   );

   // Stage 1: window update, outline decision and result queueing.
   always_comb begin
      line_old   = fwd_ff ? fwd_data_ff : line_rd;
      older_bit  = line_old[0];
      prior_bit  = line_old[1];
      line_wr    = {s1_ff.fg, prior_bit};
      window_new = {window_ff[5:0], s1_ff.fg, prior_bit, older_bit};

      en0 = s1_ff.row_nz && s1_ff.col_nz;
      en1 = s1_ff.row_nz && s1_ff.last_col;
      en2 = s1_ff.last_row;
      n_results = 2'(en0) + 2'(en1) + 2'(en2);

      res0.is_outline = window_new[4] &&
                        (s1_ff.col_one || s1_ff.row_one || window_new != ambe_pkg::WINDOW_FULL);
      res0.pixel_col  = ambe_pkg::COORD_WIDTH'(s1_ff.col - 1'b1);
      res0.pixel_row  = ambe_pkg::COORD_WIDTH'(s1_ff.row - 1'b1);
      res0.frame_done = 1'b0;
      res1.is_outline = window_new[1];
      res1.pixel_col  = ambe_pkg::COORD_WIDTH'(s1_ff.col);
      res1.pixel_row  = ambe_pkg::COORD_WIDTH'(s1_ff.row - 1'b1);
      res1.frame_done = 1'b0;
      res2.is_outline = s1_ff.fg;
      res2.pixel_col  = ambe_pkg::COORD_WIDTH'(s1_ff.col);
      res2.pixel_row  = ambe_pkg::COORD_WIDTH'(s1_ff.row);
      res2.frame_done = s1_ff.last_col;

      pack[0] = en0 ? res0 : (en1 ? res1 : res2);
      pack[1] = (en0 && en1) ? res1 : res2;
      pack[2] = res2;

      base   = count_ff - QW'(pop);
      retire = s1_valid_ff && ((base + QW'(n_results)) <= QW'(QD));

      window_in = window_ff;
      if (csr_write) begin
         window_in = '0;
      end else if (retire) begin
         window_in = window_new;
      end

      count_in = base + (retire ? QW'(n_results) : '0);
   end

   always_comb begin
      for (int i = 0; i < QD; i++) begin
         slot_idx = QW'(i) - base;
         if (pop && i < QD - 1) begin
            queue_in[i] = queue_ff[i + 1];
         end else begin
            queue_in[i] = queue_ff[i];
         end
         if (retire && QW'(i) >= base && slot_idx < QW'(n_results)) begin
            queue_in[i] = pack[slot_idx[1:0]];
         end
      end
   end

   assign rsp_tdata = ambe_pkg::RSP_TDATA_WIDTH'({queue_ff[0].pixel_row, queue_ff[0].pixel_col});
   assign rsp_tuser = queue_ff[0].is_outline;
   assign rsp_tlast = queue_ff[0].frame_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= ambe_pkg::WIDTH_RESET;
         frame_height_ff <= ambe_pkg::HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         s1_valid_ff     <= 1'b0;
         fwd_ff          <= 1'b0;
         window_ff       <= '0;
         count_ff        <= '0;
      end else begin
         if (csr_valid && csr_ready && csr_index == ambe_pkg::REG_FRAME_WIDTH) begin
            frame_width_ff <= csr_data;
         end
         if (csr_valid && csr_ready && csr_index == ambe_pkg::REG_FRAME_HEIGHT) begin
            frame_height_ff <= csr_data;
         end
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
         if (req_accept) begin
            fwd_ff <= fwd_in;
         end
         window_ff   <= window_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff       <= s1_in;
         fwd_data_ff <= fwd_data_in;
      end
      queue_ff <= queue_in;
   end

   `AMBE_ASSERT_NEVER(a_queue_overflow, count_ff > QW'(QD))
   `AMBE_ASSERT(a_stall_holds_stage, s1_valid_ff && !retire |=> s1_valid_ff && $stable(s1_ff))
   `AMBE_ASSERT_NEVER(a_col_in_frame, col_ff > col_last)
   `AMBE_ASSERT_NEVER(a_row_in_frame, row_ff > row_last)

endmodule

>>> dv/alpha_matte_boundary_extract_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha matte boundary extract checker
// Watches the pixel, result and register channels, keeps its own line masks
// and 3x3 window, predicts every outline result and compares it on arrival.
// ----------------------------------------------------------------------------
module alpha_matte_boundary_extract_unit_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [ambe_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,  // alpha
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [ambe_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,  // pixel_col, pixel_row, zeros
   input  logic                                 rsp_tuser,  // is_outline
   input  logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [ambe_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ambe_pkg::SIZE_WIDTH-1:0]      csr_data,
   output int                                   error_count,
   output int                                   pending_count,
   output int                                   result_count
);

   localparam int CDW = ambe_pkg::COORD_WIDTH;

   logic [ambe_pkg::SIZE_WIDTH-1:0] width_reg = ambe_pkg::WIDTH_RESET;
   logic [ambe_pkg::SIZE_WIDTH-1:0] height_reg = ambe_pkg::HEIGHT_RESET;
   bit                              older_mask [ambe_pkg::MAX_WIDTH];
   bit                              prior_mask [ambe_pkg::MAX_WIDTH];
   logic [8:0]                      window = '0;
   int                              col_pos = 0;
   int                              row_pos = 0;
   ambe_pkg::result_type            outline_expected [$];
   int                              mismatches = 0;
   int                              results_seen = 0;

   assign error_count  = mismatches;
   assign result_count = results_seen;

   // A size of zero behaves as one; sizes above the line buffer are clipped.
   function automatic int clip_extent(input logic [ambe_pkg::SIZE_WIDTH-1:0] value,
                                      input int cap);
      if (value == '0) return 1;
      if (int'(value) > cap) return cap;
      return int'(value);
   endfunction

   function automatic void queue_outline(input bit outline, input int col, input int row,
                                         input bit done);
      ambe_pkg::result_type res;
      res.is_outline = outline;
      res.pixel_col  = CDW'(col);
      res.pixel_row  = CDW'(row);
      res.frame_done = done;
      outline_expected.insert(outline_expected.size(), res);
   endfunction

   // Pixel at (c, r) completes the window of (c-1, r-1), closes row r-1 at the
   // last column, and on the last row also reports itself.
   function automatic void trace_outline(input logic [ambe_pkg::ALPHA_WIDTH-1:0] alpha);
      int w;
      int h;
      int c;
      int r;
      bit fg;
      bit older;
      bit prior;
      bit border;
      w = clip_extent(width_reg, ambe_pkg::MAX_WIDTH);
      h = clip_extent(height_reg, ambe_pkg::MAX_HEIGHT);
      c = (col_pos >= w) ? 0 : col_pos;
      r = (row_pos >= h) ? 0 : row_pos;
      fg = (alpha != '0);
      older = older_mask[c];
      prior = prior_mask[c];
      older_mask[c] = prior;
      prior_mask[c] = fg;
      window = {window[5:0], fg, prior, older};
      if (r >= 1) begin
         if (c >= 1) begin
            border = (c - 1 == 0) || (c - 1 == w - 1) || (r - 1 == 0) || (r - 1 == h - 1);
            queue_outline(window[4] && (border || window != ambe_pkg::WINDOW_FULL),
                          c - 1, r - 1, 1'b0);
         end
         if (c == w - 1) begin
            queue_outline(window[1], c, r - 1, 1'b0);
         end
      end
      if (r == h - 1) begin
         queue_outline(fg, c, r, c == w - 1);
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endfunction

   task automatic compare_field(input string field, input int expv, input int actv);
      if (expv != actv) begin
         $error("%s mismatch: expected %0d, got %0d", field, expv, actv);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      ambe_pkg::result_type want;
      if (reset) begin
         width_reg = ambe_pkg::WIDTH_RESET;
         height_reg = ambe_pkg::HEIGHT_RESET;
         window = '0;
         col_pos = 0;
         row_pos = 0;
         outline_expected.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (outline_expected.size() == 0) begin
               $error("Result for col %0d row %0d arrived with no request pending.",
                      rsp_tdata[CDW-1:0], rsp_tdata[2*CDW-1:CDW]);
               mismatches++;
            end else begin
               want = outline_expected.pop_front();
               compare_field("is_outline", want.is_outline, rsp_tuser);
               compare_field("pixel_col", want.pixel_col, rsp_tdata[CDW-1:0]);
               compare_field("pixel_row", want.pixel_row, rsp_tdata[2*CDW-1:CDW]);
               compare_field("frame_done", want.frame_done, rsp_tlast);
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == ambe_pkg::REG_FRAME_WIDTH ||
                csr_index == ambe_pkg::REG_FRAME_HEIGHT) begin
               if (csr_index == ambe_pkg::REG_FRAME_WIDTH) width_reg = csr_data;
               else height_reg = csr_data;
               window = '0;
               col_pos = 0;
               row_pos = 0;
            end
         end
         if (req_tvalid && req_tready) begin
            trace_outline(req_tdata[ambe_pkg::ALPHA_WIDTH-1:0]);
         end
      end
      pending_count <= outline_expected.size();
   end

endmodule

>>> dv/alpha_matte_boundary_extract_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha matte boundary extract testbench
// Streams directed and random mattes through the outline extractor under
// several frame geometries and handshake mixes; the checker scores results.
// ----------------------------------------------------------------------------
module alpha_matte_boundary_extract_unit_test;

   localparam int CYCLE_LIMIT    = 1000000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_ITEMS   = 30;
   localparam int EXTREME_ITEMS  = 40;
   localparam int SIW            = ambe_pkg::SIZE_WIDTH;
   localparam int AW             = ambe_pkg::ALPHA_WIDTH;
   localparam int XW             = ambe_pkg::CSR_INDEX_WIDTH;
   localparam logic [XW-1:0] REG_SPARE = XW'(3);

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [ambe_pkg::REQ_TDATA_WIDTH-1:0] req_tdata = '0;   // alpha
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [ambe_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata;        // pixel_col, pixel_row, zeros
   logic                                 rsp_tuser;        // is_outline
   logic                                 rsp_tlast;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [XW-1:0]                        csr_index = ambe_pkg::REG_FRAME_WIDTH;
   logic [SIW-1:0]                       csr_data = '0;

   int error_count;
   int pending_count;
   int result_count;
   int cycle_count = 0;
   int src_idle_pct = 0;
   int sink_stall_pct = 0;
   int pixels_sent = 0;
   int geometries = 1;

   alpha_matte_boundary_extract_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   alpha_matte_boundary_extract_unit_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
   end

   task automatic send_pixel(input logic [AW-1:0] alpha);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ambe_pkg::REQ_TDATA_WIDTH'(alpha);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixels_sent++;
   endtask

   // Registers may only change once the block has gone quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [XW-1:0] index, input logic [SIW-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [SIW-1:0] width, input logic [SIW-1:0] height);
      settle();
      write_reg(ambe_pkg::REG_FRAME_WIDTH, width);
      write_reg(ambe_pkg::REG_FRAME_HEIGHT, height);
      geometries++;
   endtask

   function automatic logic [AW-1:0] random_alpha(input int density);
      if ($urandom_range(99) >= density) return '0;
      if ($urandom_range(9) == 0) return '1;
      return AW'($urandom_range(1, 255));
   endfunction

   function automatic logic [SIW-1:0] pick_size(input int span, input int wide_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return '0;
      if (roll < 10 + wide_pct) return SIW'($urandom_range(4095));
      return SIW'($urandom_range(1, span));
   endfunction

   initial begin : stimulus
      int src_mix [4];
      int sink_mix [4];
      int density;
      src_mix  = '{0, 88, 0, 28};
      sink_mix = '{0, 0, 88, 28};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry of 640 x 480: a few pixels of row 0, then reconfigure
      // in the middle of the frame.
      repeat (8) send_pixel(random_alpha(70));

      configure(SIW'(3), SIW'(3));
      send_pixel(8'd255);
      send_pixel(8'd0);
      send_pixel(8'd1);
      send_pixel(8'd128);
      settle();
      // A write to an unassigned index must leave the frame position alone.
      write_reg(REG_SPARE, '1);
      send_pixel(8'd255);
      send_pixel(8'd255);
      send_pixel(8'd0);
      send_pixel(8'd255);
      send_pixel(8'd255);

      // Solid 4 x 4 block with a hole in the corner gives both a covered and
      // an exposed interior pixel.
      configure(SIW'(4), SIW'(4));
      for (int i = 0; i < 16; i++) send_pixel((i == 15) ? 8'd0 : 8'd255);

      // Zero and oversize registers: one column of clipped height, then one
      // row of clipped width.
      configure('0, '1);
      repeat (EXTREME_ITEMS) send_pixel(random_alpha(80));
      configure('1, '0);
      repeat (EXTREME_ITEMS) send_pixel(random_alpha(80));

      for (int mix = 0; mix < 4; mix++) begin
         settle();
         src_idle_pct   = src_mix[mix];
         sink_stall_pct = sink_mix[mix];
         repeat (3) begin
            configure(pick_size(12, 5), pick_size(8, 8));
            density = $urandom_range(40, 97);
            repeat (RANDOM_ITEMS) send_pixel(random_alpha(density));
         end
      end

      src_idle_pct   = 0;
      sink_stall_pct = 0;
      settle();
      $display("Streamed %0d matte pixels through %0d frame geometries", pixels_sent,
               geometries);
      $display("under four handshake mixes; %0d outline results were compared.",
               result_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
